@@ hw/rtl/cdus_pkg.sv @@
// Shared types, widths and calendar constants for the civil date to Unix seconds block.
// Depends on nothing; every other file in this block imports it.
package cdus_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int ZONE_W   = 7;
    localparam int EPOCH_W  = 39;

    localparam int DAYS_W   = 25;
    localparam int ADJ_W    = 21;

    localparam logic [YEAR_W-1:0] YEAR_MIN = YEAR_W'(1970);
    localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);

    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [17:0] DAYS_PER_ERA  = 18'd146097;
    localparam logic [19:0] EPOCH_DAYS    = 20'd719468;
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

    typedef struct packed {
        logic valid;
        logic ok;
    } t_ctl;

    // Days from 1 March to the first of the given month, in the March-based year.
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] month);
        logic [8:0] r;
        case (month)
            4'd3:    r = 9'd0;
            4'd4:    r = 9'd31;
            4'd5:    r = 9'd61;
            4'd6:    r = 9'd92;
            4'd7:    r = 9'd122;
            4'd8:    r = 9'd153;
            4'd9:    r = 9'd184;
            4'd10:   r = 9'd214;
            4'd11:   r = 9'd245;
            4'd12:   r = 9'd275;
            4'd1:    r = 9'd306;
            4'd2:    r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] r;
        case (month)
            4'd2:                        r = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:     r = 5'd30;
            default:                     r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/cdus_days.sv @@
// Three register stages: field checks, leap year test and day count since the epoch.
// Also forms the time-of-day and zone adjustment. Depends on cdus_pkg.
module cdus_days import cdus_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [YEAR_W-1:0]   i_year,
    input  logic [MONTH_W-1:0]  i_month,
    input  logic [DAY_W-1:0]    i_day,
    input  logic [HOUR_W-1:0]   i_hour,
    input  logic [MINUTE_W-1:0] i_minute,
    input  logic [SECOND_W-1:0] i_second,
    input  logic                i_zone_negative,
    input  logic [ZONE_W-1:0]   i_zone_hours,
    input  logic [ZONE_W-1:0]   i_zone_minutes,
    output t_ctl                o_ctl,
    output logic signed [DAYS_W-1:0] o_days,
    output logic signed [ADJ_W-1:0]  o_adj
);

    // Stage 1
    t_ctl                r1_ctl;
    logic [YEAR_W-1:0]   r1_year;
    logic [YEAR_W-1:0]   r1_y;
    logic [MONTH_W-1:0]  r1_month;
    logic [DAY_W-1:0]    r1_day;
    logic [26:0]         r1_prod_year;
    logic [26:0]         r1_prod_y;
    logic [8:0]          r1_doy;
    logic [16:0]         r1_tod;
    logic [18:0]         r1_zone;
    logic                r1_zneg;

    t_ctl                n1_ctl;
    logic [YEAR_W-1:0]   n1_y;
    logic [8:0]          n1_doy;
    logic [16:0]         n1_tod;
    logic [18:0]         n1_zone;

    always_comb begin
        n1_ctl.valid = i_valid;
        n1_ctl.ok    = (i_year >= YEAR_MIN) && (i_year <= YEAR_MAX)
                    && (i_month >= 4'd1) && (i_month <= 4'd12)
                    && (i_day != '0)
                    && (i_zone_hours <= 7'd23) && (i_zone_minutes <= 7'd59);
        n1_y    = (i_month <= 4'd2) ? i_year - YEAR_W'(1) : i_year;
        n1_doy  = days_before(i_month) + 9'(i_day) - 9'd1;
        n1_tod  = 17'(i_hour) * 17'd3600 + 17'(i_minute) * 17'd60 + 17'(i_second);
        n1_zone = 19'(i_zone_hours) * 19'd3600 + 19'(i_zone_minutes) * 19'd60;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else begin
            r1_ctl <= n1_ctl;
        end
        r1_year      <= i_year;
        r1_y         <= n1_y;
        r1_month     <= i_month;
        r1_day       <= i_day;
        r1_prod_year <= 27'(i_year) * 27'(RECIP_100);
        r1_prod_y    <= 27'(n1_y) * 27'(RECIP_100);
        r1_doy       <= n1_doy;
        r1_tod       <= n1_tod;
        r1_zone      <= n1_zone;
        r1_zneg      <= i_zone_negative;
    end

    // Stage 2
    t_ctl               r2_ctl;
    logic [5:0]         r2_era;
    logic [8:0]         r2_yoe;
    logic [1:0]         r2_yoe_c;
    logic [8:0]         r2_doy;
    logic signed [ADJ_W-1:0] r2_adj;

    t_ctl               n2_ctl;
    logic [7:0]         n2_q100_year;
    logic [7:0]         n2_q100_y;
    logic [6:0]         n2_rem_year;
    logic               n2_leap;
    logic [DAY_W:0]     n2_lim;
    logic [5:0]         n2_era;
    logic [8:0]         n2_yoe;
    logic [1:0]         n2_yoe_c;
    logic signed [ADJ_W-1:0] n2_adj;

    always_comb begin
        n2_q100_year = r1_prod_year[RECIP_SHIFT +: 8];
        n2_q100_y    = r1_prod_y[RECIP_SHIFT +: 8];
        n2_rem_year  = 7'(r1_year - YEAR_W'(n2_q100_year) * YEAR_W'(100));
        n2_leap      = (r1_year[1:0] == 2'd0)
                    && ((n2_rem_year != '0) || (n2_q100_year[1:0] == 2'd0));
        n2_lim       = {1'b0, month_len(r1_month)}
                     + (((r1_month == 4'd2) && n2_leap) ? 6'd1 : 6'd0);
        n2_ctl.valid = r1_ctl.valid;
        n2_ctl.ok    = r1_ctl.ok && ({1'b0, r1_day} <= n2_lim);
        n2_era       = n2_q100_y[7:2];
        n2_yoe       = 9'(r1_y - YEAR_W'(n2_era) * YEAR_W'(400));
        n2_yoe_c     = n2_q100_y[1:0];
        if (r1_zneg) begin
            n2_adj = $signed(ADJ_W'(r1_tod)) + $signed(ADJ_W'(r1_zone));
        end else begin
            n2_adj = $signed(ADJ_W'(r1_tod)) - $signed(ADJ_W'(r1_zone));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else begin
            r2_ctl <= n2_ctl;
        end
        r2_era   <= n2_era;
        r2_yoe   <= n2_yoe;
        r2_yoe_c <= n2_yoe_c;
        r2_doy   <= r1_doy;
        r2_adj   <= n2_adj;
    end

    // Stage 3
    t_ctl               r3_ctl;
    logic signed [DAYS_W-1:0] r3_days;
    logic signed [ADJ_W-1:0]  r3_adj;

    logic [18:0]        n3_doe;
    logic [DAYS_W-1:0]  n3_days;

    always_comb begin
        n3_doe  = 19'(r2_yoe) * 19'(DAYS_PER_YEAR) + 19'(r2_yoe[8:2])
                - 19'(r2_yoe_c) + 19'(r2_doy);
        n3_days = DAYS_W'(r2_era) * DAYS_W'(DAYS_PER_ERA) + DAYS_W'(n3_doe)
                - DAYS_W'(EPOCH_DAYS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else begin
            r3_ctl <= r2_ctl;
        end
        r3_days <= $signed(n3_days);
        r3_adj  <= r2_adj;
    end

    assign o_ctl  = r3_ctl;
    assign o_days = r3_days;
    assign o_adj  = r3_adj;

endmodule

@@ hw/rtl/cdus_secs.sv @@
// Final stage: scales days to seconds, adds the time of day and zone correction.
// Zeroes the result of an invalid item. Depends on cdus_pkg.
module cdus_secs import cdus_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctl                     i_ctl,
    input  logic signed [DAYS_W-1:0] i_days,
    input  logic signed [ADJ_W-1:0]  i_adj,
    output logic                     o_strobe,
    output logic [EPOCH_W-1:0]       o_epoch_seconds,
    output logic                     o_valid_res
);

    localparam int PROD_W = DAYS_W + 18;

    logic               r_strobe;
    logic               r_valid_res;
    logic [EPOCH_W-1:0] r_epoch;

    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] n_secs;

    always_comb begin
        n_prod = PROD_W'(i_days) * PROD_W'($signed({1'b0, SECS_PER_DAY}));
        n_secs = n_prod + PROD_W'(i_adj);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_ctl.valid;
        end
        r_valid_res <= i_ctl.ok;
        r_epoch     <= i_ctl.ok ? n_secs[EPOCH_W-1:0] : '0;
    end

    assign o_strobe        = r_strobe;
    assign o_epoch_seconds = r_epoch;
    assign o_valid_res     = r_valid_res;

endmodule

@@ hw/rtl/civil_date_to_unix_seconds.sv @@
// Top level: checks a parsed civil date and UTC offset and returns Unix seconds for the date, time and offset.
// Depends on cdus_pkg, cdus_days and cdus_secs.
//
//  channel   handshake          payload
//  command   start, busy        i_year .. i_zone_minutes
//  result    o_strobe           o_epoch_seconds, o_valid_res
//
// One item may enter in every cycle; busy is never raised.
// Each result passes through the four pipeline registers (checks, leap and era split,
// day count, scaling to seconds).
// Synchronous reset empties the pipeline; beats in flight are dropped.
// The receiver cannot stall, so nothing is ever held back.
module civil_date_to_unix_seconds import cdus_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [YEAR_W-1:0]   i_year,
    input  logic [MONTH_W-1:0]  i_month,
    input  logic [DAY_W-1:0]    i_day,
    input  logic [HOUR_W-1:0]   i_hour,
    input  logic [MINUTE_W-1:0] i_minute,
    input  logic [SECOND_W-1:0] i_second,
    input  logic                i_zone_negative,
    input  logic [ZONE_W-1:0]   i_zone_hours,
    input  logic [ZONE_W-1:0]   i_zone_minutes,
    output logic                o_strobe,
    output logic [EPOCH_W-1:0]  o_epoch_seconds,
    output logic                o_valid_res
);

    t_ctl                     w_ctl;
    logic signed [DAYS_W-1:0] w_days;
    logic signed [ADJ_W-1:0]  w_adj;

    assign busy = 1'b0;

    cdus_days u_days (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (start && !busy),
        .i_year          (i_year),
        .i_month         (i_month),
        .i_day           (i_day),
        .i_hour          (i_hour),
        .i_minute        (i_minute),
        .i_second        (i_second),
        .i_zone_negative (i_zone_negative),
        .i_zone_hours    (i_zone_hours),
        .i_zone_minutes  (i_zone_minutes),
        .o_ctl           (w_ctl),
        .o_days          (w_days),
        .o_adj           (w_adj)
    );

    cdus_secs u_secs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .i_days          (w_days),
        .i_adj           (w_adj),
        .o_strobe        (o_strobe),
        .o_epoch_seconds (o_epoch_seconds),
        .o_valid_res     (o_valid_res)
    );

endmodule

@@ hw/rtl/cdus_checker.sv @@
// Port-level checks of the civil date to Unix seconds block, bound to its top level.
// Depends on cdus_pkg and civil_date_to_unix_seconds.
module cdus_checker import cdus_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic [ZONE_W-1:0]   i_zone_hours,
    input logic [MONTH_W-1:0]  i_month,
    input logic                o_strobe,
    input logic [EPOCH_W-1:0]  o_epoch_seconds,
    input logic                o_valid_res
);

    // Every accepted beat gives a result strobe.
    a_beat_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_strobe)
        else $error("accepted beat gave no result");

    a_result_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 4))
        else $error("result without an accepted beat");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_valid_res) |-> (o_epoch_seconds == '0))
        else $error("invalid result carries nonzero seconds");

    a_bad_zone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (($past(i_zone_hours, 4) > 7'd23) || ($past(i_month, 4) == 4'd0)))
        |-> !o_valid_res)
        else $error("bad zone or month marked valid");

endmodule

bind civil_date_to_unix_seconds cdus_checker u_cdus_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_zone_hours    (i_zone_hours),
    .i_month         (i_month),
    .o_strobe        (o_strobe),
    .o_epoch_seconds (o_epoch_seconds),
    .o_valid_res     (o_valid_res)
);

@@ sim/tb.sv @@
// Self-checking testbench for civil_date_to_unix_seconds: directed and random civil timestamps
// are driven beat by beat and each strobed result is compared with a local calendar calculation.
// Depends on cdus_pkg for port widths and on the RTL of the block.
module tb import cdus_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIRST_YEAR   = 1970;
    localparam int LAST_YEAR    = 9999;
    localparam int RANDOM_ITEMS = 1450;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic                zone_negative;
        logic [ZONE_W-1:0]   zone_hours;
        logic [ZONE_W-1:0]   zone_minutes;
    } t_stamp;

    typedef struct packed {
        logic [EPOCH_W-1:0] seconds;
        logic               valid;
    } t_epoch;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [YEAR_W-1:0]   i_year = '0;
    logic [MONTH_W-1:0]  i_month = '0;
    logic [DAY_W-1:0]    i_day = '0;
    logic [HOUR_W-1:0]   i_hour = '0;
    logic [MINUTE_W-1:0] i_minute = '0;
    logic [SECOND_W-1:0] i_second = '0;
    logic                i_zone_negative = 1'b0;
    logic [ZONE_W-1:0]   i_zone_hours = '0;
    logic [ZONE_W-1:0]   i_zone_minutes = '0;
    logic                o_strobe;
    logic [EPOCH_W-1:0]  o_epoch_seconds;
    logic                o_valid_res;

    t_stamp stamps_to_send[$];
    t_epoch awaited_epochs[$];
    t_stamp stamp_on_bus;
    t_epoch want;
    int     idle_left = 0;
    int     burst_left = 0;
    int     roll;
    int     mismatches = 0;
    int     cycle_count = 0;

    civil_date_to_unix_seconds i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_year          (i_year),
        .i_month         (i_month),
        .i_day           (i_day),
        .i_hour          (i_hour),
        .i_minute        (i_minute),
        .i_second        (i_second),
        .i_zone_negative (i_zone_negative),
        .i_zone_hours    (i_zone_hours),
        .i_zone_minutes  (i_zone_minutes),
        .o_strobe        (o_strobe),
        .o_epoch_seconds (o_epoch_seconds),
        .o_valid_res     (o_valid_res)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int calendar_len(input int yr, input int mo);
        int leap;
        leap = ((yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0))) ? 1 : 0;
        case (mo)
            2:           return 28 + leap;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // Days are counted in 400-year eras of March-based years, then the offset is removed.
    function automatic t_epoch unix_seconds_of(input t_stamp s);
        t_epoch r;
        int     yr;
        int     mo;
        int     dy;
        longint y;
        longint era;
        longint yoe;
        longint mp;
        longint doy;
        longint doe;
        longint days;
        longint zone;
        longint secs;
        r.seconds = '0;
        r.valid = 1'b0;
        yr = int'(s.year);
        mo = int'(s.month);
        dy = int'(s.day);
        if (yr < FIRST_YEAR || yr > LAST_YEAR || mo < 1 || mo > 12 || dy < 1) return r;
        if (int'(s.zone_hours) > 23 || int'(s.zone_minutes) > 59) return r;
        if (dy > calendar_len(yr, mo)) return r;
        y    = yr - ((mo <= 2) ? 1 : 0);
        era  = y / 400;
        yoe  = y - era * 400;
        mp   = (mo > 2) ? mo - 3 : mo + 9;
        doy  = (153 * mp + 2) / 5 + dy - 1;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * 146097 + doe - 719468;
        zone = longint'(int'(s.zone_hours)) * 3600 + longint'(int'(s.zone_minutes)) * 60;
        if (s.zone_negative) zone = -zone;
        secs = days * 86400 + longint'(int'(s.hour)) * 3600 + longint'(int'(s.minute)) * 60
             + longint'(int'(s.second)) - zone;
        r.seconds = EPOCH_W'(secs);
        r.valid = 1'b1;
        return r;
    endfunction

    task automatic add_stamp(input int yr, input int mo, input int dy, input int hr,
                             input int mi, input int se, input int zn, input int zh,
                             input int zm);
        t_stamp s;
        s.year          = YEAR_W'(yr);
        s.month         = MONTH_W'(mo);
        s.day           = DAY_W'(dy);
        s.hour          = HOUR_W'(hr);
        s.minute        = MINUTE_W'(mi);
        s.second        = SECOND_W'(se);
        s.zone_negative = zn[0];
        s.zone_hours    = ZONE_W'(zh);
        s.zone_minutes  = ZONE_W'(zm);
        stamps_to_send.push_back(s);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                awaited_epochs.push_back(unix_seconds_of(stamp_on_bus));
            end
            if (!start || !busy) begin
                if (idle_left > 0 || stamps_to_send.size() == 0) begin
                    if (idle_left > 0) idle_left--;
                    start <= 1'b0;
                end else begin
                    stamp_on_bus = stamps_to_send.pop_front();
                    start           <= 1'b1;
                    i_year          <= stamp_on_bus.year;
                    i_month         <= stamp_on_bus.month;
                    i_day           <= stamp_on_bus.day;
                    i_hour          <= stamp_on_bus.hour;
                    i_minute        <= stamp_on_bus.minute;
                    i_second        <= stamp_on_bus.second;
                    i_zone_negative <= stamp_on_bus.zone_negative;
                    i_zone_hours    <= stamp_on_bus.zone_hours;
                    i_zone_minutes  <= stamp_on_bus.zone_minutes;
                    if (burst_left > 0) begin
                        burst_left--;
                        idle_left = 0;
                    end else begin
                        roll = $urandom_range(0, 99);
                        if (roll < 3) begin
                            burst_left = $urandom_range(20, 80);
                            idle_left = 0;
                        end else if (roll < 50) begin
                            idle_left = 0;
                        end else if (roll < 85) begin
                            idle_left = $urandom_range(1, 3);
                        end else if (roll < 97) begin
                            idle_left = $urandom_range(4, 12);
                        end else begin
                            idle_left = $urandom_range(20, 60);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (awaited_epochs.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing awaited: seconds %0d valid %0b",
                         $time, $signed(o_epoch_seconds), o_valid_res);
            end else begin
                want = awaited_epochs.pop_front();
                if (o_epoch_seconds !== want.seconds) begin
                    mismatches++;
                    $display("%0t: epoch_seconds expected %0d, got %0d", $time,
                             $signed(want.seconds), $signed(o_epoch_seconds));
                end
                if (o_valid_res !== want.valid) begin
                    mismatches++;
                    $display("%0t: valid_res expected %0b, got %0b", $time,
                             want.valid, o_valid_res);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL civil_date_to_unix_seconds");
            $finish;
        end
    end

    initial begin
        int kind;
        int band;
        int yr;
        int mo;
        int dy;
        int hr;
        int mi;
        int se;
        int zn;
        int zh;
        int zm;
        int len;

        add_stamp(1970, 1, 1, 0, 0, 0, 0, 0, 0);
        add_stamp(1970, 1, 1, 0, 0, 0, 0, 23, 59);
        add_stamp(9999, 12, 31, 23, 59, 61, 1, 23, 59);
        add_stamp(9999, 12, 31, 31, 63, 63, 1, 23, 59);
        add_stamp(1969, 12, 31, 23, 59, 59, 0, 0, 0);
        add_stamp(10000, 1, 1, 0, 0, 0, 0, 0, 0);
        add_stamp(16383, 15, 31, 31, 63, 63, 1, 127, 127);
        add_stamp(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_stamp(2024, 0, 10, 8, 0, 0, 0, 0, 0);
        add_stamp(2024, 13, 10, 8, 0, 0, 0, 0, 0);
        add_stamp(2024, 1, 0, 8, 0, 0, 0, 0, 0);
        add_stamp(2000, 2, 29, 12, 0, 0, 0, 0, 0);
        add_stamp(2100, 2, 29, 12, 0, 0, 0, 0, 0);
        add_stamp(2024, 2, 29, 12, 0, 0, 0, 0, 0);
        add_stamp(2023, 2, 29, 12, 0, 0, 0, 0, 0);
        add_stamp(2400, 2, 29, 12, 0, 0, 0, 0, 0);
        add_stamp(2023, 4, 31, 6, 30, 0, 0, 0, 0);
        add_stamp(2023, 4, 30, 6, 30, 0, 0, 0, 0);
        add_stamp(2023, 1, 31, 6, 30, 0, 0, 0, 0);
        add_stamp(2023, 3, 1, 0, 0, 0, 0, 0, 0);
        add_stamp(2023, 6, 15, 12, 0, 0, 0, 24, 0);
        add_stamp(2023, 6, 15, 12, 0, 0, 1, 5, 60);
        add_stamp(2023, 6, 15, 12, 30, 0, 1, 5, 30);
        add_stamp(2038, 1, 19, 3, 14, 7, 0, 0, 0);

        // Mostly well-formed timestamps, some with one field broken, the rest pure noise.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
                add_stamp($urandom_range(0, 16383), $urandom_range(0, 15),
                          $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 1), $urandom_range(0, 127),
                          $urandom_range(0, 127));
            end else begin
                band = $urandom_range(0, 99);
                if (band < 10) begin
                    yr = $urandom_range(1970, 1973);
                end else if (band < 20) begin
                    yr = $urandom_range(9996, 9999);
                end else if (band < 30) begin
                    yr = $urandom_range(2096, 2104);
                end else begin
                    yr = $urandom_range(FIRST_YEAR, LAST_YEAR);
                end
                mo = $urandom_range(1, 12);
                len = calendar_len(yr, mo);
                dy = ($urandom_range(0, 9) == 0) ? len : $urandom_range(1, len);
                if ($urandom_range(0, 19) == 0) begin
                    hr = $urandom_range(0, 31);
                    mi = $urandom_range(0, 63);
                    se = $urandom_range(0, 63);
                end else begin
                    hr = $urandom_range(0, 23);
                    mi = $urandom_range(0, 59);
                    se = $urandom_range(0, 61);
                end
                zn = $urandom_range(0, 1);
                zh = $urandom_range(0, 23);
                zm = $urandom_range(0, 59);
                if (kind < 35) begin
                    case ($urandom_range(0, 4))
                        0: yr = $urandom_range(0, 1) ? $urandom_range(0, FIRST_YEAR - 1)
                                                     : $urandom_range(LAST_YEAR + 1, 16383);
                        1: begin
                            mo = $urandom_range(0, 3);
                            if (mo != 0) mo = mo + 12;
                        end
                        2: dy = (len < 31 && $urandom_range(0, 1)) ? $urandom_range(len + 1, 31)
                                                                   : 0;
                        3: zh = $urandom_range(24, 127);
                        default: zm = $urandom_range(60, 127);
                    endcase
                end
                add_stamp(yr, mo, dy, hr, mi, se, zn, zh, zm);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stamps_to_send.size() != 0 || start || awaited_epochs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && awaited_epochs.size() == 0) begin
            $display("PASS civil_date_to_unix_seconds");
        end else begin
            $display("FAIL civil_date_to_unix_seconds");
        end
        $finish;
    end

endmodule
